FILE: sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, status codes and layout helpers for the buddy allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int UNIT_BYTES_DEF = 128;
    localparam int TOP_ORDER_DEF  = 10;
    localparam int TOP_BLOCKS_DEF = 32;

    localparam int REQ_W   = 17;
    localparam int UNITF_W = 15;
    localparam int ORD_W   = 4;
    localparam int LIVE_W  = 16;
    localparam int HDR_W   = 7;
    localparam int ST_W    = 2;
    localparam int OWN_W   = 5;
    localparam int WORD_W  = 32;
    localparam int BIT_W   = 5;

    localparam logic [HDR_W-1:0] HDR_RESET = 7'd40;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_REQ = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD_FREE = 2'd3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // bitmap words holding one order
    function automatic int words_at(input int tb, input int to, input int o);
        return ((tb << (to - o)) + 31) >> 5;
    endfunction

    // first bitmap word of one order
    function automatic int base_words(input int tb, input int to, input int o);
        int s;
        s = 0;
        for (int j = 0; j < o; j++)
            s = s + words_at(tb, to, j);
        return s;
    endfunction

    function automatic int free_words(input int tb, input int to);
        return base_words(tb, to, to + 1);
    endfunction

endpackage

`default_nettype wire

FILE: sv/bba_first_one.sv
// ----------------------------------------------------------------------------
// bba_first_one
// Lowest set bit of one bitmap word.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_first_one
(
    input  wire logic [bba_pkg::WORD_W-1:0] word,
    output logic                            any,
    output logic [bba_pkg::BIT_W-1:0]       idx
);

    always_comb
    begin
        idx = '0;
        for (int i = bba_pkg::WORD_W - 1; i >= 0; i--)
        begin
            if (word[i])
            begin
                idx = bba_pkg::BIT_W'(i);
            end
        end
    end

    assign any = |word;

endmodule

`default_nettype wire

FILE: sv/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over bitmap words of free blocks per order and a per-unit
// owner table, run by a small sequencer one bitmap word per step.
//
// channel  dir  signals
// in       in   in_valid/in_ready: kind, request_bytes, block_unit
// out      out  out_valid/out_ready: status, granted_unit, granted_order,
//               live_blocks
// cfg      in   cfg_wr_en, cfg_wr_data (header_bytes)
//
// Alloc: sizing, a read and check per word scanned, a read and write per
//   split, owner write, result. Free: owner read and check, a read and check
//   per merge level, release read and write, result. Bitmap accesses share
//   the single bitmap RAM port pair (registered read). After reset a clearing
//   pass over the bitmap and owner table runs with in_ready low.
// A result waits in the output register; the next transfer is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator
#(
    parameter int UNIT_BYTES = bba_pkg::UNIT_BYTES_DEF,
    parameter int TOP_ORDER  = bba_pkg::TOP_ORDER_DEF,
    parameter int TOP_BLOCKS = bba_pkg::TOP_BLOCKS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          kind,
    input  wire logic [bba_pkg::REQ_W-1:0]     request_bytes,
    input  wire logic [bba_pkg::UNITF_W-1:0]   block_unit,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [bba_pkg::ST_W-1:0]           status,
    output logic [bba_pkg::UNITF_W-1:0]        granted_unit,
    output logic [bba_pkg::ORD_W-1:0]          granted_order,
    output logic [bba_pkg::LIVE_W-1:0]         live_blocks,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bba_pkg::HDR_W-1:0]     cfg_wr_data
);

    localparam int TOTAL_UNITS = TOP_BLOCKS << TOP_ORDER;
    localparam int FREE_WORDS  = bba_pkg::free_words(TOP_BLOCKS, TOP_ORDER);
    localparam int UW  = $clog2(TOTAL_UNITS);
    localparam int FAW = $clog2(FREE_WORDS);
    localparam int IW  = FAW + bba_pkg::BIT_W;
    localparam int OW  = $clog2(TOP_ORDER + 1);
    localparam int CLR_LEN = (TOTAL_UNITS > FREE_WORDS) ? TOTAL_UNITS : FREE_WORDS;
    localparam int CW  = $clog2(CLR_LEN + 1);
    localparam int CAPW0 = $clog2(UNIT_BYTES) + TOP_ORDER + 1;
    localparam int CMPW  = ((CAPW0 > 18) ? CAPW0 : 18) + 1;
    localparam int TOP_BASE = bba_pkg::base_words(TOP_BLOCKS, TOP_ORDER, TOP_ORDER);
    localparam logic [63:0] TOP_MASK = (TOP_BLOCKS >= 64) ? {64{1'b1}}
                                       : ((64'd1 << TOP_BLOCKS) - 64'd1);

    localparam logic [4:0] S_CLR       = 5'd0;
    localparam logic [4:0] S_IDLE      = 5'd1;
    localparam logic [4:0] S_SIZE      = 5'd2;
    localparam logic [4:0] S_SCAN_RD   = 5'd3;
    localparam logic [4:0] S_SCAN_CHK  = 5'd4;
    localparam logic [4:0] S_SPLIT_RD  = 5'd5;
    localparam logic [4:0] S_SPLIT_WR  = 5'd6;
    localparam logic [4:0] S_OWN_WR    = 5'd7;
    localparam logic [4:0] S_FREE_RD   = 5'd8;
    localparam logic [4:0] S_FREE_CHK  = 5'd9;
    localparam logic [4:0] S_MERGE_RD  = 5'd10;
    localparam logic [4:0] S_MERGE_CHK = 5'd11;
    localparam logic [4:0] S_REL_RD    = 5'd12;
    localparam logic [4:0] S_REL_WR    = 5'd13;
    localparam logic [4:0] S_RES       = 5'd14;

    logic [4:0]                     state_reg, state_next;
    logic [CW-1:0]                  clr_reg, clr_next;
    logic [bba_pkg::HDR_W-1:0]      hdr_reg;
    logic [bba_pkg::REQ_W-1:0]      req_reg, req_next;
    logic [OW-1:0]                  ord_reg, ord_next;
    logic [OW-1:0]                  need_reg, need_next;
    logic [FAW-1:0]                 wcnt_reg, wcnt_next;
    logic [UW-1:0]                  unit_reg, unit_next;
    logic [FAW-1:0]                 waddr_reg, waddr_next;
    logic [bba_pkg::BIT_W-1:0]      wbit_reg, wbit_next;
    logic [bba_pkg::LIVE_W-1:0]     live_reg, live_next;
    logic [bba_pkg::ST_W-1:0]       res_st_reg, res_st_next;
    logic [bba_pkg::UNITF_W-1:0]    res_unit_reg, res_unit_next;
    logic [bba_pkg::ORD_W-1:0]      res_ord_reg, res_ord_next;
    logic                           out_valid_reg;
    logic [bba_pkg::ST_W-1:0]       out_st_reg;
    logic [bba_pkg::UNITF_W-1:0]    out_unit_reg;
    logic [bba_pkg::ORD_W-1:0]      out_ord_reg;
    logic [bba_pkg::LIVE_W-1:0]     out_live_reg;

    logic [FAW-1:0] base_w [0:TOP_ORDER];
    logic [FAW-1:0] last_w [0:TOP_ORDER];

    genvar go;
    generate
        for (go = 0; go <= TOP_ORDER; go++)
        begin : g_layout
            assign base_w[go] = FAW'(bba_pkg::base_words(TOP_BLOCKS, TOP_ORDER, go));
            assign last_w[go] = FAW'(bba_pkg::words_at(TOP_BLOCKS, TOP_ORDER, go) - 1);
        end
    endgenerate

    // bitmap and owner memories
    logic [bba_pkg::WORD_W-1:0] fm_mem [0:FREE_WORDS-1];
    logic [bba_pkg::OWN_W-1:0]  own_mem [0:TOTAL_UNITS-1];
    logic                       fm_we;
    logic [FAW-1:0]             fm_waddr, fm_raddr;
    logic [bba_pkg::WORD_W-1:0] fm_wdata, fm_rdata_reg;
    logic                       own_we;
    logic [UW-1:0]              own_waddr;
    logic [bba_pkg::OWN_W-1:0]  own_wdata, own_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (fm_we)
        begin
            fm_mem[fm_waddr] <= fm_wdata;
        end
        fm_rdata_reg <= fm_mem[fm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            own_mem[own_waddr] <= own_wdata;
        end
        own_rdata_reg <= own_mem[unit_reg];
    end

    // address of a block bit from order and unit
    logic [OW-1:0]  calc_ord;
    logic [UW-1:0]  calc_unit;
    logic [IW-1:0]  calc_pos;
    logic [FAW-1:0] calc_addr;
    logic [FAW-1:0] scan_addr;

    always_comb
    begin
        calc_ord  = ord_reg;
        calc_unit = unit_reg;
        case (state_reg)
            S_SPLIT_RD:
            begin
                calc_ord  = ord_reg - OW'(1);
                calc_unit = unit_reg | (UW'(1) << (ord_reg - OW'(1)));
            end
            S_MERGE_RD:
            begin
                calc_unit = unit_reg ^ (UW'(1) << ord_reg);
            end
            default:
            begin
                calc_ord  = ord_reg;
                calc_unit = unit_reg;
            end
        endcase
    end

    assign calc_pos  = IW'(calc_unit) >> calc_ord;
    assign calc_addr = base_w[calc_ord] + calc_pos[IW-1:bba_pkg::BIT_W];
    assign scan_addr = base_w[ord_reg] + wcnt_reg;
    assign fm_raddr  = (state_reg == S_SCAN_RD) ? scan_addr : calc_addr;

    logic                      pe_any;
    logic [bba_pkg::BIT_W-1:0] pe_idx;

    bba_first_one u_first_one
    (
        .word (fm_rdata_reg),
        .any  (pe_any),
        .idx  (pe_idx)
    );

    logic [CMPW-1:0]            need_sum;
    logic [CMPW-1:0]            cap;
    logic [IW-1:0]              found_idx;
    logic [bba_pkg::WORD_W-1:0] wbit_mask;
    logic [bba_pkg::WORD_W-1:0] clr_word;
    logic                       res_free;

    assign need_sum  = CMPW'(req_reg) + CMPW'(hdr_reg);
    assign cap       = CMPW'(UNIT_BYTES) << ord_reg;
    assign found_idx = {wcnt_reg, pe_idx};
    assign wbit_mask = bba_pkg::WORD_W'(1) << wbit_reg;
    assign res_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        if (clr_reg == CW'(TOP_BASE))
            clr_word = TOP_MASK[31:0];
        else if (clr_reg == CW'(TOP_BASE + 1))
            clr_word = TOP_MASK[63:32];
        else
            clr_word = '0;
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        req_next      = req_reg;
        ord_next      = ord_reg;
        need_next     = need_reg;
        wcnt_next     = wcnt_reg;
        unit_next     = unit_reg;
        waddr_next    = waddr_reg;
        wbit_next     = wbit_reg;
        live_next     = live_reg;
        res_st_next   = res_st_reg;
        res_unit_next = res_unit_reg;
        res_ord_next  = res_ord_reg;
        fm_we         = 1'b0;
        fm_waddr      = waddr_reg;
        fm_wdata      = fm_rdata_reg | wbit_mask;
        own_we        = 1'b0;
        own_waddr     = unit_reg;
        own_wdata     = '0;

        case (state_reg)
            S_CLR:
            begin
                if (clr_reg < CW'(FREE_WORDS))
                begin
                    fm_we    = 1'b1;
                    fm_waddr = clr_reg[FAW-1:0];
                    fm_wdata = clr_word;
                end
                if (clr_reg < CW'(TOTAL_UNITS))
                begin
                    own_we    = 1'b1;
                    own_waddr = clr_reg[UW-1:0];
                end
                clr_next = clr_reg + CW'(1);
                if (clr_reg == CW'(CLR_LEN - 1))
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next      = request_bytes;
                    ord_next      = '0;
                    wcnt_next     = '0;
                    unit_next     = UW'(block_unit);
                    res_unit_next = '0;
                    res_ord_next  = '0;
                    if (kind == bba_pkg::KIND_ALLOC)
                    begin
                        if (request_bytes == '0)
                        begin
                            res_st_next = bba_pkg::ST_BAD_REQ;
                            state_next  = S_RES;
                        end
                        else
                            state_next = S_SIZE;
                    end
                    else if (32'(block_unit) >= 32'(TOTAL_UNITS))
                    begin
                        res_st_next = bba_pkg::ST_BAD_FREE;
                        state_next  = S_RES;
                    end
                    else
                        state_next = S_FREE_RD;
                end
            end

            S_SIZE:
            begin
                if (need_sum <= cap)
                begin
                    need_next  = ord_reg;
                    state_next = S_SCAN_RD;
                end
                else if (ord_reg == OW'(TOP_ORDER))
                begin
                    res_st_next = bba_pkg::ST_BAD_REQ;
                    state_next  = S_RES;
                end
                else
                    ord_next = ord_reg + OW'(1);
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if (pe_any)
                begin
                    fm_we     = 1'b1;
                    fm_waddr  = scan_addr;
                    fm_wdata  = fm_rdata_reg & ~(bba_pkg::WORD_W'(1) << pe_idx);
                    unit_next = UW'(found_idx << ord_reg);
                    if (ord_reg > need_reg)
                        state_next = S_SPLIT_RD;
                    else
                        state_next = S_OWN_WR;
                end
                else if (wcnt_reg == last_w[ord_reg])
                begin
                    wcnt_next = '0;
                    if (ord_reg == OW'(TOP_ORDER))
                    begin
                        res_st_next = bba_pkg::ST_NO_FREE;
                        state_next  = S_RES;
                    end
                    else
                    begin
                        ord_next   = ord_reg + OW'(1);
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    wcnt_next  = wcnt_reg + FAW'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_SPLIT_RD:
            begin
                waddr_next = calc_addr;
                wbit_next  = calc_pos[bba_pkg::BIT_W-1:0];
                ord_next   = ord_reg - OW'(1);
                state_next = S_SPLIT_WR;
            end

            S_SPLIT_WR:
            begin
                fm_we = 1'b1;
                if (ord_reg > need_reg)
                    state_next = S_SPLIT_RD;
                else
                    state_next = S_OWN_WR;
            end

            S_OWN_WR:
            begin
                own_we        = 1'b1;
                own_wdata     = bba_pkg::OWN_W'(need_reg) + bba_pkg::OWN_W'(1);
                live_next     = live_reg + bba_pkg::LIVE_W'(1);
                res_st_next   = bba_pkg::ST_OK;
                res_unit_next = bba_pkg::UNITF_W'(unit_reg);
                res_ord_next  = bba_pkg::ORD_W'(need_reg);
                state_next    = S_RES;
            end

            S_FREE_RD:
            begin
                state_next = S_FREE_CHK;
            end

            S_FREE_CHK:
            begin
                if (own_rdata_reg == '0)
                begin
                    res_st_next = bba_pkg::ST_BAD_FREE;
                    state_next  = S_RES;
                end
                else
                begin
                    own_we   = 1'b1;
                    ord_next = OW'(own_rdata_reg - bba_pkg::OWN_W'(1));
                    if (OW'(own_rdata_reg - bba_pkg::OWN_W'(1)) == OW'(TOP_ORDER))
                        state_next = S_REL_RD;
                    else
                        state_next = S_MERGE_RD;
                end
            end

            S_MERGE_RD:
            begin
                waddr_next = calc_addr;
                wbit_next  = calc_pos[bba_pkg::BIT_W-1:0];
                state_next = S_MERGE_CHK;
            end

            S_MERGE_CHK:
            begin
                if (fm_rdata_reg[wbit_reg])
                begin
                    fm_we     = 1'b1;
                    fm_wdata  = fm_rdata_reg & ~wbit_mask;
                    unit_next = unit_reg & ~(UW'(1) << ord_reg);
                    ord_next  = ord_reg + OW'(1);
                    if (ord_reg + OW'(1) == OW'(TOP_ORDER))
                        state_next = S_REL_RD;
                    else
                        state_next = S_MERGE_RD;
                end
                else
                    state_next = S_REL_RD;
            end

            S_REL_RD:
            begin
                waddr_next = calc_addr;
                wbit_next  = calc_pos[bba_pkg::BIT_W-1:0];
                state_next = S_REL_WR;
            end

            S_REL_WR:
            begin
                fm_we        = 1'b1;
                live_next    = live_reg - bba_pkg::LIVE_W'(1);
                res_st_next  = bba_pkg::ST_OK;
                res_ord_next = bba_pkg::ORD_W'(ord_reg);
                state_next   = S_RES;
            end

            S_RES:
            begin
                if (res_free)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            hdr_reg       <= bba_pkg::HDR_RESET;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            live_reg  <= live_next;
            if (cfg_wr_en)
                hdr_reg <= cfg_wr_data;
            if (state_reg == S_RES && res_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        ord_reg      <= ord_next;
        need_reg     <= need_next;
        wcnt_reg     <= wcnt_next;
        unit_reg     <= unit_next;
        waddr_reg    <= waddr_next;
        wbit_reg     <= wbit_next;
        res_st_reg   <= res_st_next;
        res_unit_reg <= res_unit_next;
        res_ord_reg  <= res_ord_next;
        if (state_reg == S_RES && res_free)
        begin
            out_st_reg   <= res_st_reg;
            out_unit_reg <= res_unit_reg;
            out_ord_reg  <= res_ord_reg;
            out_live_reg <= live_reg;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_st_reg;
    assign granted_unit  = out_unit_reg;
    assign granted_order = out_ord_reg;
    assign live_blocks   = out_live_reg;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for buddy_block_allocator: a queue-fed driver sends
// allocate and free transfers in random bursts, a shadow allocator in the
// bench predicts each result, and a monitor checks it under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int UNIT_B     = bba_pkg::UNIT_BYTES_DEF;
    localparam int TOP_ORD    = bba_pkg::TOP_ORDER_DEF;
    localparam int TOP_BLKS   = bba_pkg::TOP_BLOCKS_DEF;
    localparam int N_UNITS    = TOP_BLKS << TOP_ORD;
    localparam int FREE_DEPTH = TOP_BLKS * ((2 << TOP_ORD) - 1);
    localparam longint CYCLE_LIMIT = 40000000;

    typedef struct packed {
        logic                        kind;
        logic [bba_pkg::REQ_W-1:0]   req;
        logic [bba_pkg::UNITF_W-1:0] unit;
    } xfer_t;

    typedef struct packed {
        logic [bba_pkg::ST_W-1:0]    st;
        logic [bba_pkg::UNITF_W-1:0] unit;
        logic [bba_pkg::ORD_W-1:0]   ord;
        logic [bba_pkg::LIVE_W-1:0]  live;
    } grant_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind = 1'b0;
    logic [bba_pkg::REQ_W-1:0] request_bytes = '0;
    logic [bba_pkg::UNITF_W-1:0] block_unit = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [bba_pkg::ST_W-1:0] status;
    logic [bba_pkg::UNITF_W-1:0] granted_unit;
    logic [bba_pkg::ORD_W-1:0] granted_order;
    logic [bba_pkg::LIVE_W-1:0] live_blocks;
    logic cfg_wr_en = 1'b0;
    logic [bba_pkg::HDR_W-1:0] cfg_wr_data = '0;

    // shadow state
    bit free_blk [FREE_DEPTH];
    logic [bba_pkg::OWN_W-1:0] owner [N_UNITS];
    logic [bba_pkg::LIVE_W-1:0] live_cnt;
    int hdr;
    int held_units[$];

    xfer_t pending[$];
    grant_t expected_grants[$];
    int mismatches = 0;
    longint cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_phase = 0;
    bit sending = 1'b0;

    buddy_block_allocator u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .request_bytes(request_bytes), .block_unit(block_unit),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .granted_unit(granted_unit),
        .granted_order(granted_order), .live_blocks(live_blocks),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // first shadow bit of one order
    function automatic int order_base(int ord);
        int base;
        base = 0;
        for (int j = 0; j < ord; j++)
            base = base + (TOP_BLKS << (TOP_ORD - j));
        return base;
    endfunction

    function automatic void reset_shadow();
        foreach (free_blk[i])
            free_blk[i] = 1'b0;
        for (int i = 0; i < TOP_BLKS; i++)
            free_blk[order_base(TOP_ORD) + i] = 1'b1;
        foreach (owner[i])
            owner[i] = '0;
        live_cnt = '0;
        hdr = int'(bba_pkg::HDR_RESET);
    endfunction

    function automatic grant_t predict_grant(xfer_t x);
        grant_t g;
        int need;
        int ord;
        int idx;
        int u;
        int bud;
        int pos;
        bit hit;
        g = '0;
        if (x.kind == bba_pkg::KIND_ALLOC)
        begin
            need = TOP_ORD + 1;
            for (int k = TOP_ORD; k >= 0; k--)
                if (longint'(x.req) + longint'(hdr) <= (longint'(UNIT_B) << k))
                    need = k;
            if (x.req == '0 || need > TOP_ORD)
                g.st = bba_pkg::ST_BAD_REQ;
            else
            begin
                hit = 1'b0;
                idx = 0;
                for (ord = need; ord <= TOP_ORD; ord++)
                begin
                    pos = order_base(ord);
                    for (int i = 0; i < (TOP_BLKS << (TOP_ORD - ord)); i++)
                    begin
                        if (free_blk[pos + i])
                        begin
                            idx = i;
                            hit = 1'b1;
                            break;
                        end
                    end
                    if (hit)
                        break;
                end
                if (!hit)
                    g.st = bba_pkg::ST_NO_FREE;
                else
                begin
                    free_blk[order_base(ord) + idx] = 1'b0;
                    u = idx << ord;
                    while (ord > need)
                    begin
                        ord--;
                        free_blk[order_base(ord) + ((u + (1 << ord)) >> ord)] = 1'b1;
                    end
                    owner[u] = bba_pkg::OWN_W'(need + 1);
                    live_cnt = live_cnt + bba_pkg::LIVE_W'(1);
                    held_units.push_back(u);
                    g.st = bba_pkg::ST_OK;
                    g.unit = bba_pkg::UNITF_W'(u);
                    g.ord = bba_pkg::ORD_W'(need);
                end
            end
        end
        else
        begin
            u = int'(x.unit);
            if (u >= N_UNITS || owner[u] == '0)
                g.st = bba_pkg::ST_BAD_FREE;
            else
            begin
                ord = int'(owner[u]) - 1;
                owner[u] = '0;
                while (ord < TOP_ORD)
                begin
                    bud = u ^ (1 << ord);
                    pos = order_base(ord) + (bud >> ord);
                    if (!free_blk[pos])
                        break;
                    free_blk[pos] = 1'b0;
                    if (bud < u)
                        u = bud;
                    ord++;
                end
                free_blk[order_base(ord) + (u >> ord)] = 1'b1;
                live_cnt = live_cnt - bba_pkg::LIVE_W'(1);
                g.st = bba_pkg::ST_OK;
                g.ord = bba_pkg::ORD_W'(ord);
            end
        end
        g.live = live_cnt;
        return g;
    endfunction

    function automatic int rand_req();
        case ($urandom_range(0, 9))
            0:       return int'($urandom_range(0, 131071));
            1:       return int'($urandom_range(0, 3));
            2:       return int'($urandom_range(100000, 131071));
            default: return int'($urandom_range(1, 2000));
        endcase
    endfunction

    task automatic add_alloc(int req);
        xfer_t x;
        x.kind = bba_pkg::KIND_ALLOC;
        x.req = bba_pkg::REQ_W'(req);
        x.unit = bba_pkg::UNITF_W'($urandom_range(0, 32767));
        pending.push_back(x);
    endtask

    task automatic add_free(int u);
        xfer_t x;
        x.kind = bba_pkg::KIND_FREE;
        x.req = bba_pkg::REQ_W'($urandom_range(0, 131071));
        x.unit = bba_pkg::UNITF_W'(u);
        pending.push_back(x);
    endtask

    task automatic wait_idle();
        while (pending.size() != 0 || expected_grants.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_header(int value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= bba_pkg::HDR_W'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // random phase: frees taken from the held list reference blocks that are
    // granted by the time they reach the front of the queue; other frees name any unit
    task automatic fill_random(int count);
        int est;
        est = 0;
        for (int n = 0; n < count; n++)
        begin
            while (pending.size() >= 8)
                @(posedge clk);
            if (held_units.size() > 0 && $urandom_range(0, 99) < 45)
            begin
                if (pending.size() == 0 || held_units.size() > pending.size())
                begin
                    est = int'($urandom_range(0, held_units.size() - 1));
                    add_free(held_units[est]);
                    held_units.delete(est);
                end
                else
                    add_alloc(rand_req());
            end
            else if ($urandom_range(0, 99) < 5)
                add_free(int'($urandom_range(0, 32767)));
            else
                add_alloc(rand_req());
            @(posedge clk);
        end
    endtask

    // Driver: the front of the queue is held on the port until its transfer.
    always @(posedge clk)
    begin
        xfer_t x;
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                x = pending.pop_front();
                expected_grants.push_back(predict_grant(x));
                sending = 1'b0;
            end
            if (!sending)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending.size() != 0)
                begin
                    if (burst_left == 0)
                        burst_left = int'($urandom_range(1, 40));
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 2) == 0) ? 0
                                   : int'($urandom_range(1, 150));
                    x = pending[0];
                    kind <= x.kind;
                    request_bytes <= x.req;
                    block_unit <= x.unit;
                    sending = 1'b1;
                end
            end
            in_valid <= sending;
        end
    end

    always @(posedge clk)
    begin
        grant_t g;
        grant_t act;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                act.st = status;
                act.unit = granted_unit;
                act.ord = granted_order;
                act.live = live_blocks;
                if (expected_grants.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: %p", act);
                end
                else
                begin
                    g = expected_grants.pop_front();
                    if (g !== act)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", g, act);
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 97;
            if (stall_phase < 30)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int hdr_set[5];
        reset_shadow();
        hdr_set = '{0, 127, 1, 64, 40};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed, default header
        add_alloc(0);
        add_alloc(131071);
        add_alloc(88);
        add_alloc(89);
        add_alloc(131072 - 40);
        add_alloc(131072 - 39);
        add_free(N_UNITS - 1);
        add_free(32767);
        add_free(0);
        add_free(0);
        add_free(1);
        add_free(2);
        for (int i = 0; i < 33; i++)
            add_alloc(100000);
        add_alloc(1);
        add_free(0);
        wait_idle();

        foreach (hdr_set[h])
        begin
            write_header(hdr_set[h]);
            hdr = hdr_set[h];
            if (h == 1)
            begin
                add_alloc(1);
                add_alloc(131072 - 127);
                add_alloc(131072 - 128);
            end
            fill_random(380);
            wait_idle();
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
